@@ sv/dfa_pkg.sv @@
// shared types and constants for the detrended fluctuation analysis block
// depends on nothing; imported by every module of the block but dfa_mul
package dfa_pkg;

    localparam int WIN_W   = 11;
    localparam int STAT_W  = 2;
    localparam int MSF_W   = 58;
    localparam int FLUCT_W = 29;
    localparam int NSQ_W   = 22;   // n*n for an 11-bit window
    localparam int DT_W    = 44;   // n*n*(n*n-1)

    localparam logic [WIN_W-1:0] WIN_RESET = 11'd4;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_SHORT  = 2'd1,
        STAT_NOTMUL = 2'd2,
        STAT_OVF    = 2'd3
    } dfa_stat_t;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MSEL_QN = 3'd0,   // sum(y^2) * n
        MSEL_YY = 3'd1,   // |sum y|^2
        MSEL_EE = 3'd2,   // |e|^2
        MSEL_CN = 3'd3,   // cyy * (n^2-1)
        MSEL_D1 = 3'd4,   // n^2 * (n^2-1)
        MSEL_D2 = 3'd5    // previous * block count
    } dfa_msel_t;

    typedef struct packed {
        logic      load;
        logic      chk_init;
        logic      chk_step;
        logic      stat_wr;
        dfa_stat_t stat;
        logic      blk_init;
        logic      acc;
        logic      prod;
        logic      sum;
        logic      mul_start;
        dfa_msel_t msel;
        logic      mul_cap;
        logic      e_calc;
        logic      tot_add;
        logic      div_start;
        logic      finish;
    } dfa_cmd_t;

    typedef struct packed {
        logic ovf;
        logic win_short;
        logic rem_ge;
        logic rem_zero;
        logic elem_last;
        logic blk_last;
        logic mul_done;
        logic div_done;
    } dfa_sts_t;

endpackage

@@ sv/dfa_mul.sv @@
// iterative shift-and-add multiplier, one bit of b per cycle
// depends on nothing but its parameters
module dfa_mul #(
    parameter int A_W = 66,
    parameter int B_W = 45
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] p
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    // one partial product per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg <= '0;
                a_reg   <= P_W'(a);
                b_reg   <= b;
                cnt_reg <= CNT_W'(B_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

@@ sv/dfa_divsqrt.sv @@
// q16 divider followed by a floor square root, one bit per cycle
// depends on dfa_pkg
module dfa_divsqrt
    import dfa_pkg::*;
#(
    parameter int TOT_W = 99,
    parameter int DEN_W = 55
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOT_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [MSF_W-1:0]   msf,
    output logic [FLUCT_W-1:0] root
);

    localparam int DV_N  = TOT_W + 16;
    localparam int DC_W  = $clog2(DV_N + 1);
    localparam int SR_W  = FLUCT_W + 1;
    localparam int SQ_W  = SR_W + 2;

    typedef enum logic [1:0] {PH_IDLE, PH_DIV, PH_SQRT} ph_t;

    ph_t                ph_reg;
    logic [DC_W-1:0]    cnt_reg;
    logic [DV_N-1:0]    dv_reg;
    logic [DEN_W:0]     rem_reg;
    logic [MSF_W-1:0]   q_reg;
    logic               sat_reg;
    logic [MSF_W-1:0]   msf_reg;
    logic [MSF_W-1:0]   rad_reg;
    logic [SR_W-1:0]    srem_reg;
    logic [FLUCT_W-1:0] root_reg;
    logic               done_reg;

    logic [DEN_W:0]     r2;
    logic               dge;
    logic [MSF_W-1:0]   q_nx;
    logic               sat_nx;
    logic [SQ_W-1:0]    sr;
    logic [SQ_W-1:0]    trial;
    logic               sge;

    // restoring division step
    always_comb
    begin
        r2     = {rem_reg[DEN_W-1:0], dv_reg[DV_N-1]};
        dge    = r2 >= {1'b0, den};
        q_nx   = {q_reg[MSF_W-2:0], dge};
        sat_nx = sat_reg | q_reg[MSF_W-1];
    end

    // square root step, two radicand bits at a time
    always_comb
    begin
        sr    = {srem_reg, rad_reg[MSF_W-1:MSF_W-2]};
        trial = {1'b0, root_reg, 2'b01};
        sge   = sr >= trial;
    end

    // sequencer and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (ph_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        dv_reg  <= {num, 16'd0};
                        rem_reg <= '0;
                        q_reg   <= '0;
                        sat_reg <= 1'b0;
                        cnt_reg <= DC_W'(DV_N);
                        ph_reg  <= PH_DIV;
                    end
                end
                PH_DIV:
                begin
                    rem_reg <= dge ? r2 - {1'b0, den} : r2;
                    dv_reg  <= dv_reg << 1;
                    q_reg   <= q_nx;
                    sat_reg <= sat_nx;
                    cnt_reg <= cnt_reg - DC_W'(1);
                    if (cnt_reg == DC_W'(1))
                    begin
                        msf_reg  <= sat_nx ? '1 : q_nx;
                        rad_reg  <= sat_nx ? '1 : q_nx;
                        srem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg  <= DC_W'(FLUCT_W);
                        ph_reg   <= PH_SQRT;
                    end
                end
                PH_SQRT:
                begin
                    if (sge)
                    begin
                        srem_reg <= SR_W'(sr - trial);
                        root_reg <= {root_reg[FLUCT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= SR_W'(sr);
                        root_reg <= {root_reg[FLUCT_W-2:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg - DC_W'(1);
                    if (cnt_reg == DC_W'(1))
                    begin
                        done_reg <= 1'b1;
                        ph_reg   <= PH_IDLE;
                    end
                end
                default:
                begin
                    ph_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign msf  = msf_reg;
    assign root = root_reg;

endmodule

@@ sv/dfa_datapath.sv @@
// sample store, block accumulators, shared multiplier and result registers
// depends on dfa_pkg, dfa_mul and dfa_divsqrt
module dfa_datapath
    import dfa_pkg::*;
#(
    parameter int MAX_SERIES  = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dfa_cmd_t               cmd,
    output dfa_sts_t               sts,
    input  logic                   cfg_we,
    input  logic [WIN_W-1:0]       cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [STAT_W-1:0]      status,
    output logic [MSF_W-1:0]       mean_sq_fluct,
    output logic [FLUCT_W-1:0]     fluct
);

    localparam int CNT_W   = $clog2(MAX_SERIES + 1);
    localparam int ADDR_W  = $clog2(MAX_SERIES);
    localparam int CMP_W   = CNT_W + WIN_W;
    localparam int Y_W     = SAMPLE_BITS + 11;
    localparam int YY_W    = 2 * Y_W - 1;
    localparam int KY_W    = Y_W + 12;
    localparam int YS_W    = SAMPLE_BITS + 22;
    localparam int TS_W    = SAMPLE_BITS + 32;
    localparam int Q_W     = 2 * SAMPLE_BITS + 31;
    localparam int E_W     = SAMPLE_BITS + 34;
    localparam int NYS_W   = YS_W + 13;
    localparam int C_W     = 2 * SAMPLE_BITS + 42;
    localparam int A_W     = C_W;
    localparam int B_W     = E_W - 1;
    localparam int P_W     = A_W + B_W;
    localparam int TOT_W   = 2 * SAMPLE_BITS + 64 + CNT_W;
    localparam int DEN_W   = DT_W + CNT_W;

    // configuration and load state
    logic [WIN_W-1:0]       win_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ovf_reg;
    logic [SAMPLE_BITS-1:0] mem [MAX_SERIES];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    // walk and block state
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       nblk_reg;
    logic [CNT_W-1:0]       blk_reg;
    logic [CNT_W-1:0]       ptr_reg;
    logic [WIN_W-1:0]       j_reg;
    logic [NSQ_W-1:0]       nsq_reg;
    logic [NSQ_W-1:0]       nn1_reg;
    logic signed [Y_W-1:0]  y_reg;
    logic [YY_W-1:0]        yy_reg;
    logic signed [KY_W-1:0] ky_reg;
    logic signed [YS_W-1:0] ysum_reg;
    logic signed [TS_W-1:0] tsum_reg;
    logic [Q_W-1:0]         qsum_reg;
    logic signed [E_W-1:0]  e_reg;
    logic [P_W-1:0]         cyya_reg;
    logic [C_W-1:0]         cyy_reg;
    logic [P_W-1:0]         e2_reg;
    logic [P_W-1:0]         term_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [DT_W-1:0]        dt_reg;
    logic [DEN_W-1:0]       den_reg;
    dfa_stat_t              stat_reg;

    // result registers
    logic [STAT_W-1:0]      status_reg;
    logic [MSF_W-1:0]       msf_out_reg;
    logic [FLUCT_W-1:0]     fluct_out_reg;

    logic [NSQ_W-1:0]       nsq_w;
    logic [WIN_W-1:0]       k_w;
    logic [2*Y_W-1:0]       yy_w;
    logic signed [KY_W-1:0] ky_w;
    logic signed [NYS_W-1:0] nys_w;
    logic [WIN_W:0]         np1_w;
    logic signed [E_W-1:0]  e_w;
    logic [YS_W-1:0]        ysum_mag;
    logic [E_W-1:0]         e_mag;
    logic [A_W-1:0]         mul_a;
    logic [B_W-1:0]         mul_b;
    logic [P_W-1:0]         mul_p;
    logic                   mul_done;
    logic [MSF_W-1:0]       ds_msf;
    logic [FLUCT_W-1:0]     ds_root;
    logic                   ds_done;

    // sample store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CNT_W'(MAX_SERIES)))
        begin
            mem[count_reg[ADDR_W-1:0]] <= sample;
        end
        rdata_reg <= mem[ptr_reg[ADDR_W-1:0]];
    end

    // small arithmetic around the accumulators
    always_comb
    begin
        nsq_w    = NSQ_W'(win_reg) * NSQ_W'(win_reg);
        k_w      = j_reg + WIN_W'(1);
        yy_w     = unsigned'((2 * Y_W)'(y_reg) * (2 * Y_W)'(y_reg));
        ky_w     = signed'({1'b0, k_w}) * y_reg;
        np1_w    = {1'b0, win_reg} + (WIN_W + 1)'(1);
        nys_w    = signed'({1'b0, np1_w}) * ysum_reg;
        e_w      = (E_W'(tsum_reg) <<< 1) - E_W'(nys_w);
        ysum_mag = ysum_reg[YS_W-1] ? YS_W'(-ysum_reg) : YS_W'(ysum_reg);
        e_mag    = e_reg[E_W-1] ? E_W'(-e_reg) : E_W'(e_reg);
    end

    // multiplier operand select
    always_comb
    begin
        case (cmd.msel)
            MSEL_QN:
            begin
                mul_a = A_W'(qsum_reg);
                mul_b = B_W'(win_reg);
            end
            MSEL_YY:
            begin
                mul_a = A_W'(ysum_mag);
                mul_b = B_W'(ysum_mag);
            end
            MSEL_EE:
            begin
                mul_a = A_W'(e_mag);
                mul_b = B_W'(e_mag);
            end
            MSEL_CN:
            begin
                mul_a = A_W'(cyy_reg);
                mul_b = B_W'(nn1_reg);
            end
            MSEL_D1:
            begin
                mul_a = A_W'(nsq_reg);
                mul_b = B_W'(nn1_reg);
            end
            MSEL_D2:
            begin
                mul_a = A_W'(dt_reg);
                mul_b = B_W'(nblk_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dfa_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    dfa_divsqrt #(
        .TOT_W (TOT_W),
        .DEN_W (DEN_W)
    ) u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (total_reg),
        .den   (den_reg),
        .done  (ds_done),
        .msf   (ds_msf),
        .root  (ds_root)
    );

    // control state: window, fill count, overflow, status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= WIN_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            stat_reg  <= STAT_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (count_reg < CNT_W'(MAX_SERIES))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.stat_wr)
            begin
                stat_reg <= cmd.stat;
            end
        end
    end

    // block walk and per-block arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.chk_init)
        begin
            rem_reg   <= count_reg;
            nblk_reg  <= '0;
            blk_reg   <= '0;
            ptr_reg   <= '0;
            total_reg <= '0;
            nsq_reg   <= nsq_w;
            nn1_reg   <= nsq_w - NSQ_W'(1);
        end
        if (cmd.chk_step)
        begin
            rem_reg  <= rem_reg - CNT_W'(win_reg);
            nblk_reg <= nblk_reg + CNT_W'(1);
        end
        if (cmd.blk_init)
        begin
            y_reg    <= '0;
            ysum_reg <= '0;
            tsum_reg <= '0;
            qsum_reg <= '0;
            j_reg    <= '0;
        end
        if (cmd.acc)
        begin
            y_reg <= y_reg + Y_W'(rdata_reg);
        end
        if (cmd.prod)
        begin
            yy_reg <= yy_w[YY_W-1:0];
            ky_reg <= ky_w;
        end
        if (cmd.sum)
        begin
            ysum_reg <= ysum_reg + YS_W'(y_reg);
            tsum_reg <= tsum_reg + TS_W'(ky_reg);
            qsum_reg <= qsum_reg + Q_W'(yy_reg);
            j_reg    <= k_w;
            ptr_reg  <= ptr_reg + CNT_W'(1);
        end
        if (cmd.e_calc)
        begin
            e_reg <= e_w;
        end
        if (cmd.mul_cap)
        begin
            case (cmd.msel)
                MSEL_QN: cyya_reg <= mul_p;
                MSEL_YY: cyy_reg  <= (cyya_reg >= mul_p) ? C_W'(cyya_reg - mul_p) : '0;
                MSEL_EE: e2_reg   <= mul_p + (mul_p << 1);
                MSEL_CN: term_reg <= (mul_p >= e2_reg) ? mul_p - e2_reg : '0;
                MSEL_D1: dt_reg   <= mul_p[DT_W-1:0];
                MSEL_D2: den_reg  <= mul_p[DEN_W-1:0];
                default: den_reg  <= den_reg;
            endcase
        end
        if (cmd.tot_add)
        begin
            total_reg <= total_reg + TOT_W'(term_reg);
            blk_reg   <= blk_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            status_reg <= stat_reg;
            if (stat_reg == STAT_OK)
            begin
                msf_out_reg   <= ds_msf;
                fluct_out_reg <= ds_root;
            end
            else
            begin
                msf_out_reg   <= '0;
                fluct_out_reg <= '0;
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.ovf       = ovf_reg;
        sts.win_short = win_reg < WIN_W'(2);
        sts.rem_ge    = CMP_W'(rem_reg) >= CMP_W'(win_reg);
        sts.rem_zero  = rem_reg == '0;
        sts.elem_last = k_w == win_reg;
        sts.blk_last  = (blk_reg + CNT_W'(1)) == nblk_reg;
        sts.mul_done  = mul_done;
        sts.div_done  = ds_done;
    end

    assign status        = status_reg;
    assign mean_sq_fluct = msf_out_reg;
    assign fluct         = fluct_out_reg;

endmodule

@@ sv/dfa_ctrl.sv @@
// controller: load, error checks, block walk, multiplier and divider sequencing
// depends on dfa_pkg
module dfa_ctrl
    import dfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     last,
    input  dfa_sts_t sts,
    output dfa_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MOD, S_BLK, S_RD, S_ACC, S_PROD, S_SUM,
        S_MGO, S_MWAIT, S_ECALC, S_TOT, S_DGO, S_DWAIT, S_DONE
    } state_t;

    state_t    state_reg;
    dfa_msel_t sel_reg;
    logic      busy_reg;
    logic      done_reg;

    // command decode
    always_comb
    begin
        cmd      = '0;
        cmd.msel = sel_reg;
        cmd.stat = STAT_OK;
        unique case (state_reg)
            S_IDLE:  cmd.load = start;
            S_CHECK:
            begin
                if (sts.ovf)
                begin
                    cmd.stat_wr = 1'b1;
                    cmd.stat    = STAT_OVF;
                end
                else if (sts.win_short)
                begin
                    cmd.stat_wr = 1'b1;
                    cmd.stat    = STAT_SHORT;
                end
                else
                begin
                    cmd.chk_init = 1'b1;
                end
            end
            S_MOD:
            begin
                if (sts.rem_ge)
                begin
                    cmd.chk_step = 1'b1;
                end
                else
                begin
                    cmd.stat_wr = 1'b1;
                    cmd.stat    = sts.rem_zero ? STAT_OK : STAT_NOTMUL;
                end
            end
            S_BLK:   cmd.blk_init  = 1'b1;
            S_RD:    cmd.load      = 1'b0;
            S_ACC:   cmd.acc       = 1'b1;
            S_PROD:  cmd.prod      = 1'b1;
            S_SUM:   cmd.sum       = 1'b1;
            S_MGO:   cmd.mul_start = 1'b1;
            S_MWAIT: cmd.mul_cap   = sts.mul_done;
            S_ECALC: cmd.e_calc    = 1'b1;
            S_TOT:   cmd.tot_add   = 1'b1;
            S_DGO:   cmd.div_start = 1'b1;
            S_DWAIT: cmd.load      = 1'b0;
            S_DONE:  cmd.finish    = 1'b1;
            default: cmd.load      = 1'b0;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= MSEL_QN;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && last)
                    begin
                        state_reg <= S_CHECK;
                        busy_reg  <= 1'b1;
                    end
                end
                S_CHECK:
                begin
                    state_reg <= (sts.ovf || sts.win_short) ? S_DONE : S_MOD;
                end
                S_MOD:
                begin
                    if (!sts.rem_ge)
                    begin
                        state_reg <= sts.rem_zero ? S_BLK : S_DONE;
                    end
                end
                S_BLK:  state_reg <= S_RD;
                S_RD:   state_reg <= S_ACC;
                S_ACC:  state_reg <= S_PROD;
                S_PROD: state_reg <= S_SUM;
                S_SUM:
                begin
                    if (sts.elem_last)
                    begin
                        sel_reg   <= MSEL_QN;
                        state_reg <= S_MGO;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_MGO:  state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (sts.mul_done)
                    begin
                        unique case (sel_reg)
                            MSEL_QN:
                            begin
                                sel_reg   <= MSEL_YY;
                                state_reg <= S_MGO;
                            end
                            MSEL_YY: state_reg <= S_ECALC;
                            MSEL_EE:
                            begin
                                sel_reg   <= MSEL_CN;
                                state_reg <= S_MGO;
                            end
                            MSEL_CN: state_reg <= S_TOT;
                            MSEL_D1:
                            begin
                                sel_reg   <= MSEL_D2;
                                state_reg <= S_MGO;
                            end
                            MSEL_D2: state_reg <= S_DGO;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_ECALC:
                begin
                    sel_reg   <= MSEL_EE;
                    state_reg <= S_MGO;
                end
                S_TOT:
                begin
                    if (sts.blk_last)
                    begin
                        sel_reg   <= MSEL_D1;
                        state_reg <= S_MGO;
                    end
                    else
                    begin
                        state_reg <= S_BLK;
                    end
                end
                S_DGO:  state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ sv/detrended_fluctuation_analysis.sv @@
// top level of the dfa1 fluctuation block: controller plus datapath
// depends on dfa_pkg, dfa_ctrl and dfa_datapath
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+----------------------------------
//   input     | start, busy               | sample, last
//   config    | cfg_valid, cfg_ready      | cfg_data (window_length)
//   result    | done (one-cycle strobe)   | status, mean_sq_fluct, fluct
//
// samples load one per cycle while busy is low; the item marked last starts
// the computation and busy stays high until the result strobe
// the computation runs a remainder check, then per block a walk of the store
// plus four passes of the bit-serial multiplier (B_W = SAMPLE_BITS+33),
// two more passes for the divisor, then the divider and the square root
// an error result comes straight from the checks, with no block walk
// reset clears counts and control; the store needs no clearing pass
// the result is shown for exactly one cycle and cannot be held off
module detrended_fluctuation_analysis
    import dfa_pkg::*;
#(
    parameter int MAX_SERIES  = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [WIN_W-1:0]       cfg_data,
    output logic                   done,
    output logic [STAT_W-1:0]      status,
    output logic [MSF_W-1:0]       mean_sq_fluct,
    output logic [FLUCT_W-1:0]     fluct
);

    dfa_cmd_t cmd;
    dfa_sts_t sts;
    logic     cfg_we;

    // configuration is taken only while idle
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    dfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dfa_datapath #(
        .MAX_SERIES  (MAX_SERIES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .status        (status),
        .mean_sq_fluct (mean_sq_fluct),
        .fluct         (fluct)
    );

    // the result strobe comes with the block ready for a new item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a marked item starts the computation
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> busy)
        else $error("marked item did not start computation");

    // error results carry zero values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (mean_sq_fluct == '0 && fluct == '0))
        else $error("error result with nonzero value");

    // no strobe without a computation in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without computation");

endmodule

@@ test/dfa_checker.sv @@
// checker for the dfa1 fluctuation block: tracks series loads and window writes,
// predicts each result and compares it field by field; depends on dfa_pkg
`timescale 1ns / 1ps

module dfa_checker
    import dfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [11:0]        sample,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [WIN_W-1:0]   cfg_data,
    input  logic               done,
    input  logic [STAT_W-1:0]  status,
    input  logic [MSF_W-1:0]   mean_sq_fluct,
    input  logic [FLUCT_W-1:0] fluct,
    output int                 errors,
    output int                 pending
);

    localparam int SERIES_DEPTH = 1024;
    localparam logic [MSF_W-1:0] MSF_SAT = '1;

    typedef struct {
        dfa_stat_t         stat;
        logic [MSF_W-1:0]  msf;
        logic [FLUCT_W-1:0] root;
    } fluct_result_t;

    logic signed [11:0] series_mem [SERIES_DEPTH];
    int unsigned        series_len;
    logic               series_ovf;
    logic [WIN_W-1:0]   window;
    fluct_result_t      expected_q [$];

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // mean residual variance over blocks, as floor(2^16 * value), saturated
    function automatic logic [MSF_W-1:0] mean_residual_var(input int unsigned cnt,
                                                          input int unsigned n);
        int unsigned  nblock;
        longint       y, ysum, tsum, e;
        logic [63:0]  qsum, ymag, emag, nn1, den;
        logic [191:0] total, qn, yy, cyy, term, ee, quot;
        nblock = cnt / n;
        nn1    = 64'(n) * 64'(n) - 1;
        total  = 0;
        for (int b = 0; b < nblock; b++)
        begin
            y = 0; ysum = 0; tsum = 0; qsum = 0;
            for (int j = 0; j < n; j++)
            begin
                y    = y + series_mem[b * n + j];
                ysum = ysum + y;
                tsum = tsum + longint'(j + 1) * y;
                ymag = (y < 0) ? -y : y;
                qsum = qsum + ymag * ymag;
            end
            ymag = (ysum < 0) ? -ysum : ysum;
            qn   = 192'(qsum) * 192'(n);
            yy   = 192'(ymag) * 192'(ymag);
            cyy  = (qn < yy) ? 192'd0 : qn - yy;
            e    = 2 * tsum - longint'(n + 1) * ysum;
            emag = (e < 0) ? -e : e;
            ee   = 192'd3 * 192'(emag) * 192'(emag);
            term = cyy * 192'(nn1);
            total += (term < ee) ? 192'd0 : term - ee;
        end
        den  = 64'(n) * 64'(n) * nn1 * 64'(nblock);
        quot = total / 192'(den);
        if (quot > 192'(MSF_SAT >> 16))
            return MSF_SAT;
        return MSF_W'((total << 16) / 192'(den));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fluct_result_t r;
        if (!rst_n)
        begin
            series_len = 0;
            series_ovf = 1'b0;
            window     = WIN_RESET;
            expected_q.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            // compare the result strobe with the oldest expectation
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    r = expected_q.pop_front();
                    if (status !== r.stat)
                        report_mismatch("status", 64'(status), 64'(r.stat));
                    if (mean_sq_fluct !== r.msf)
                        report_mismatch("mean_sq_fluct", 64'(mean_sq_fluct), 64'(r.msf));
                    if (fluct !== r.root)
                        report_mismatch("fluct", 64'(fluct), 64'(r.root));
                end
            end
            // window register write
            if (cfg_valid && cfg_ready)
                window = cfg_data;
            // accepted item: store, and on the marked one predict
            if (start && !busy)
            begin
                if (series_len < SERIES_DEPTH)
                begin
                    series_mem[series_len] = sample;
                    series_len++;
                end
                else
                    series_ovf = 1'b1;
                if (last)
                begin
                    r.msf = '0;
                    if (series_ovf)
                        r.stat = STAT_OVF;
                    else if (window < 2)
                        r.stat = STAT_SHORT;
                    else if (series_len % window != 0)
                        r.stat = STAT_NOTMUL;
                    else
                    begin
                        r.stat = STAT_OK;
                        r.msf  = mean_residual_var(series_len, window);
                    end
                    r.root = FLUCT_W'(floor_sqrt(64'(r.msf)));
                    expected_q.push_back(r);
                    series_len = 0;
                    series_ovf = 1'b0;
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ test/tb_detrended_fluctuation_analysis.sv @@
// testbench top for the dfa1 fluctuation block: drives series and window writes
// depends on dfa_pkg, detrended_fluctuation_analysis and dfa_checker
`timescale 1ns / 1ps

module tb_detrended_fluctuation_analysis
    import dfa_pkg::*;
;

    localparam int CYCLE_LIMIT = 4000000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [11:0]        sample;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WIN_W-1:0]   cfg_data;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [MSF_W-1:0]   mean_sq_fluct;
    logic [FLUCT_W-1:0] fluct;
    int                 errors;
    int                 pending;
    int                 items_sent;
    int                 idle_pct;
    int                 cycles;

    detrended_fluctuation_analysis u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .done(done), .status(status),
        .mean_sq_fluct(mean_sq_fluct), .fluct(fluct)
    );

    dfa_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .done(done), .status(status),
        .mean_sq_fluct(mean_sq_fluct), .fluct(fluct),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // send one item, then maybe idle
    task automatic send_item(input logic [11:0] s, input logic is_last);
        start  <= 1'b1;
        sample <= s;
        last   <= is_last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        idle_pct = (items_sent < 317) ? 26 : (items_sent < 634) ? 55 : 0;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // random sample with the extremes mixed in
    function automatic logic [11:0] pick_sample();
        case ($urandom_range(9))
            0: return 12'h800;
            1: return 12'h7ff;
            2: return 12'(int'($urandom_range(0, 8)) - 4);
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_series(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(), i == len - 1);
    endtask

    // window write once all results are in and the block has settled
    task automatic set_window(input logic [WIN_W-1:0] w);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int n, len;
        rst_n      = 1'b0;
        start      = 1'b0;
        sample     = '0;
        last       = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cycles     = 0;
        items_sent = 0;
        idle_pct   = 26;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset window with extremes, then short and odd windows
        send_item(12'h800, 1'b0);
        send_item(12'h7ff, 1'b0);
        send_item(12'h000, 1'b0);
        send_item(12'hfff, 1'b1);
        send_series(3);
        set_window(11'd0);
        send_series(1);
        set_window(11'd1);
        send_series(2);
        set_window(11'd2);
        for (int i = 0; i < 4; i++)
            send_item(12'h7ff, i == 3);
        send_item(12'h800, 1'b0);
        send_item(12'h7ff, 1'b1);
        set_window(11'h7ff);
        send_series(2);

        // random: groups of series under one window
        while (items_sent < 930)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
            set_window(11'(n));
            repeat ($urandom_range(3, 6))
            begin
                if ($urandom_range(99) < 15)
                    len = $urandom_range(1, 3 * n);
                else
                    len = n * $urandom_range(1, 4);
                send_series(len);
            end
        end

        // a short closing series under a fixed window
        set_window(11'd8);
        send_series(16);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
